>>> design/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Shared constants, types and the quarter-wave sine table builder for the
// tone sweep envelope synthesizer.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_WIDTH    = 16;

    localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
    localparam int ROM_AW      = SINE_TABLE_BITS - 1;
    localparam int MAG_W       = SAMPLE_WIDTH - 1;
    localparam int ENV_W       = 17;
    localparam int PROD_W      = MAG_W + ENV_W;
    localparam int EXT_W       = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
    localparam int PHASE_W     = 24;
    localparam int STEP_W      = 32;

    localparam longint unsigned FULL_SCALE  = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(17'h10000);

    localparam int DIV_N_W   = 32;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = 6;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_DELTA = DIV_CNT_W'(32);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_ENV   = DIV_CNT_W'(16);

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic CFG_ATTACK  = 1'b0;
    localparam logic CFG_RELEASE = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_D_W-1:0]   rem_init;
        logic [DIV_N_W-1:0]   dividend;
        logic [DIV_D_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

    // taylor series in q30, rounded and clamped to full scale
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (longint'(k) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 156;
        sum  = sum + term;
        v    = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
        if (v > FULL_SCALE) begin
            v = FULL_SCALE;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

>>> design/tse_sine_rom.sv
// ----------------------------------------------------------------------------
// tse_sine_rom
// Quarter-wave sine table with a registered read port.
// ----------------------------------------------------------------------------
module tse_sine_rom import tse_pkg::*; (
    input  logic              i_clk,
    input  logic [ROM_AW-1:0] i_addr,
    output logic [MAG_W-1:0]  o_data
);

    logic [MAG_W-1:0] w_rom [0:QUARTER_LEN];
    logic [MAG_W-1:0] r_data;

    for (genvar g = 0; g <= QUARTER_LEN; g++) begin : g_rom
        assign w_rom[g] = sine_entry(g);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

>>> design/tse_div.sv
// ----------------------------------------------------------------------------
// tse_div
// Radix-2 restoring divider, one quotient bit per cycle, shared between the
// sweep step and the envelope ramps.
// ----------------------------------------------------------------------------
module tse_div import tse_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_dvs;
    logic [DIV_N_W-1:0]   r_dvd;
    logic [DIV_N_W-1:0]   r_quo;

    logic [DIV_D_W:0] w_shift;
    logic [DIV_D_W:0] w_trial;
    logic             w_ge;

    assign w_shift = {r_rem, r_dvd[DIV_N_W-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};
    assign w_ge    = !w_trial[DIV_D_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_dvs <= i_req.divisor;
            r_dvd <= i_req.dividend;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[DIV_D_W-1:0] : w_shift[DIV_D_W-1:0];
            r_dvd <= {r_dvd[DIV_N_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_N_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dvs))
        else $error("partial remainder not below divisor");

endmodule

>>> design/tone_sweep_envelope_synth_top.sv
// ----------------------------------------------------------------------------
// tone_sweep_envelope_synth_top
// Sine oscillator with linear step sweep and linear attack/release envelope.
// Tick: ROM state, then ENV waiting on the shared divider only when the
// envelope ramps, then MUL1, MUL2 and DONE; an idle tick goes straight to
// DONE. Start: busy in DELTA until the divider is done. Ready again once
// the result is registered, even while it waits at the output.
// Synchronous active-low reset: idle, no note, registers at default lengths.
// ----------------------------------------------------------------------------
module tone_sweep_envelope_synth_top import tse_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [22:0]        i_start_step,
    input  logic [22:0]        i_end_step,
    input  logic [15:0]        i_length_samples,
    input  logic [15:0]        i_volume,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample,
    output logic               o_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DELTA = 3'd1;
    localparam logic [2:0] S_ROM   = 3'd2;
    localparam logic [2:0] S_ENV   = 3'd3;
    localparam logic [2:0] S_MUL1  = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]  r_state;
    logic        r_playing;
    logic        r_out_valid;
    logic [15:0] r_attack;
    logic [15:0] r_release;

    logic [PHASE_W-1:0] r_phase;
    logic [STEP_W-1:0]  r_cur_step;
    logic [STEP_W-1:0]  r_delta;
    logic [15:0]        r_index;
    logic [15:0]        r_length;
    logic [15:0]        r_volume;
    logic               r_diff_neg;
    logic               r_zero;
    logic [ENV_W-1:0]   r_env;
    logic [PROD_W-1:0]  r_prod;
    logic [15:0]        r_sample;
    logic               r_last;

    logic                       w_accept;
    logic                       w_out_free;
    logic [23:0]                w_diff;
    logic [23:0]                w_diff_mag;
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [1:0]                 w_quad;
    logic [ROM_AW-1:0]          w_k0;
    logic [ROM_AW-1:0]          w_rom_addr;
    logic [MAG_W-1:0]           w_rom_data;
    logic                       w_in_attack;
    logic                       w_in_release;
    logic                       w_env_div;
    logic [MAG_W-1:0]           w_mul_a;
    logic [ENV_W-1:0]           w_mul_b;
    logic [PROD_W-1:0]          w_prod;
    logic [MAG_W-1:0]           w_mag;
    logic [EXT_W-1:0]           w_ext;
    logic [EXT_W-1:0]           w_signed;
    logic                       w_final;
    t_div_req                   w_div_req;
    t_div_rsp                   w_div_rsp;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // sweep step difference
    assign w_diff     = {1'b0, i_end_step} - {1'b0, i_start_step};
    assign w_diff_mag = w_diff[23] ? -w_diff : w_diff;

    // quarter-wave addressing
    assign w_idx      = r_phase[PHASE_W-1 -: SINE_TABLE_BITS];
    assign w_quad     = w_idx[SINE_TABLE_BITS-1 -: 2];
    assign w_k0       = {1'b0, w_idx[SINE_TABLE_BITS-3:0]};
    assign w_rom_addr = w_quad[0] ? ROM_AW'(QUARTER_LEN) - w_k0 : w_k0;

    tse_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    // envelope segment
    assign w_in_attack  = (r_index < r_attack);
    assign w_in_release = !w_in_attack &&
                          (({1'b0, r_index} + {1'b0, r_release}) > {1'b0, r_length});
    assign w_env_div    = w_in_attack || w_in_release;

    always_comb begin
        w_div_req = '0;
        if (r_state == S_IDLE) begin
            w_div_req.start    = w_accept && (i_cmd == CMD_START) &&
                                 (i_length_samples != 16'd0);
            w_div_req.steps    = DIV_STEPS_DELTA;
            w_div_req.rem_init = '0;
            w_div_req.dividend = DIV_N_W'({w_diff_mag[22:0], 8'h00});
            w_div_req.divisor  = i_length_samples;
        end else begin
            w_div_req.start    = (r_state == S_ROM) && w_env_div;
            w_div_req.steps    = DIV_STEPS_ENV;
            w_div_req.rem_init = w_in_attack ? r_index : (r_length - r_index);
            w_div_req.dividend = '0;
            w_div_req.divisor  = w_in_attack ? r_attack : r_release;
        end
    end

    tse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // shared multiplier: table times volume, then times envelope
    assign w_mul_a = (r_state == S_MUL1) ? w_rom_data : r_prod[MAG_W+15:16];
    assign w_mul_b = (r_state == S_MUL1) ? {1'b0, r_volume} : r_env;
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    assign w_mag    = r_prod[MAG_W+15:16];
    assign w_ext    = EXT_W'(w_mag);
    assign w_signed = w_quad[1] ? -w_ext : w_ext;
    assign w_final  = (({1'b0, r_index} + 17'd1) >= {1'b0, r_length});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_playing   <= 1'b0;
            r_out_valid <= 1'b0;
            r_attack    <= 16'd441;
            r_release   <= 16'd2205;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ATTACK:  r_attack  <= i_cfg_wdata;
                    CFG_RELEASE: r_release <= i_cfg_wdata;
                endcase
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_cmd == CMD_START) begin
                            r_playing <= 1'b0;
                            if (i_length_samples != 16'd0) begin
                                r_state <= S_DELTA;
                            end
                        end else if (r_playing) begin
                            r_state <= S_ROM;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DELTA: begin
                    if (w_div_rsp.done) begin
                        r_playing <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_ROM: begin
                    r_state <= w_env_div ? S_ENV : S_MUL1;
                end
                S_ENV: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        if (!r_zero && w_final) begin
                            r_playing <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_zero <= !r_playing;
                    if (i_cmd == CMD_START) begin
                        r_phase    <= '0;
                        r_index    <= '0;
                        r_length   <= i_length_samples;
                        r_volume   <= i_volume;
                        r_cur_step <= STEP_W'({i_start_step, 8'h00});
                        r_delta    <= '0;
                        r_diff_neg <= w_diff[23];
                    end
                end
            end
            S_DELTA: begin
                if (w_div_rsp.done) begin
                    r_delta <= r_diff_neg ? -w_div_rsp.quotient : w_div_rsp.quotient;
                end
            end
            S_ROM: begin
                if (!w_env_div) begin
                    r_env <= ENV_ONE;
                end
            end
            S_ENV: begin
                if (w_div_rsp.done) begin
                    r_env <= ENV_W'(w_div_rsp.quotient[15:0]);
                end
            end
            S_MUL1, S_MUL2: begin
                r_prod <= w_prod;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_sample <= r_zero ? 16'd0 : w_signed[15:0];
                    r_last   <= r_zero ? 1'b0 : w_final;
                    if (!r_zero) begin
                        r_phase    <= r_phase + r_cur_step[STEP_W-1:8];
                        r_cur_step <= r_cur_step + r_delta;
                        r_index    <= r_index + 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_last      = r_last;

    a_index_in_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_playing) |-> (r_index < r_length))
        else $error("sample index past note length while playing");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_ENV || r_state == S_DELTA))
        else $error("divider finished outside a waiting state");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done state");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tone sweep envelope synthesizer. A scoreboard
// tracks the note state and predicts every tick's sample and last flag.
// Directed notes come first: idle ticks, a zero-length note, extreme steps
// and volume, an aborted note and the shortest ramps. Random note
// sequences follow under several register settings, with random request
// gaps and output stalls in all but the last.
// ----------------------------------------------------------------------------
import tse_pkg::*;

class sample_scoreboard;
    bit [15:0] attack_len;
    bit [15:0] release_len;
    bit [23:0] phase;
    bit [31:0] cur_step;
    bit [32:0] step_delta;
    bit [15:0] sample_idx;
    bit [15:0] note_len;
    bit [15:0] note_vol;
    bit        playing;
    bit [63:0] wave [QUARTER_LEN+1];
    bit [15:0] exp_sample [$];
    bit        exp_last [$];
    int        errors;
    int        checked;

    function new();
        bit [63:0] x, x2, term, sum, v;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            x    = (64'(k) * HALF_PI_Q30) / QUARTER_LEN;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
            if (v > FULL_SCALE) begin
                v = FULL_SCALE;
            end
            wave[k] = v;
        end
        attack_len  = 16'd441;
        release_len = 16'd2205;
        phase       = '0;
        cur_step    = '0;
        step_delta  = '0;
        sample_idx  = '0;
        note_len    = '0;
        note_vol    = '0;
        playing     = 1'b0;
        errors      = 0;
        checked     = 0;
    endfunction

    function void set_lengths(bit [15:0] attack, bit [15:0] rel);
        attack_len  = attack;
        release_len = rel;
    endfunction

    function int pending();
        return exp_sample.size();
    endfunction

    function void note_request(logic cmd, bit [22:0] st, bit [22:0] en,
                               bit [15:0] len, bit [15:0] vol);
        bit [63:0]   dmag;
        bit [63:0]   mag;
        bit [63:0]   env;
        bit [63:0]   span;
        bit [15:0]   sval;
        bit [9:0]    tidx;
        bit [1:0]    quad;
        int unsigned k;
        int unsigned i;
        bit          fin;
        if (cmd == CMD_START) begin
            phase      = '0;
            sample_idx = '0;
            note_len   = len;
            note_vol   = vol;
            cur_step   = st << 8;
            step_delta = '0;
            if (len != 0) begin
                if (en < st) begin
                    dmag = st - en;
                end else begin
                    dmag = en - st;
                end
                dmag = (dmag << 8) / len;
                if (en < st) begin
                    dmag = -dmag;
                end
                step_delta = dmag[32:0];
            end
            playing = (len != 0);
            return;
        end
        if (!playing) begin
            exp_sample = {exp_sample, 16'd0};
            exp_last   = {exp_last, 1'b0};
            return;
        end
        i    = sample_idx;
        tidx = phase >> (PHASE_W - SINE_TABLE_BITS);
        quad = tidx >> (SINE_TABLE_BITS - 2);
        k    = tidx % QUARTER_LEN;
        if (quad[0]) begin
            k = QUARTER_LEN - k;
        end
        mag = wave[k];
        if (i < attack_len) begin
            env = i;
            env = (env << 16) / attack_len;
        end else if (i + release_len > note_len) begin
            span = note_len - i;
            env  = (span << 16) / release_len;
        end else begin
            env = 64'd65536;
        end
        mag  = (((mag * note_vol) >> 16) * env) >> 16;
        sval = mag[15:0];
        if (quad[1]) begin
            sval = -sval;
        end
        phase      = phase + cur_step[31:8];
        cur_step   = cur_step + step_delta[31:0];
        sample_idx = i + 1;
        fin        = (i + 1 >= note_len);
        if (fin) begin
            playing = 1'b0;
        end
        exp_sample = {exp_sample, sval};
        exp_last   = {exp_last, fin};
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 200) begin
            $display("mismatch at result %0d: %s", checked, msg);
        end
    endtask

    task check_sample(logic [15:0] got_sample, logic got_last);
        bit [15:0] want_sample;
        bit        want_last;
        if (exp_sample.size() == 0) begin
            report($sformatf("unexpected sample %0d", $signed(got_sample)));
            return;
        end
        want_sample = exp_sample.pop_front();
        want_last   = exp_last.pop_front();
        if (got_sample !== want_sample) begin
            report($sformatf("sample got %0d want %0d",
                             $signed(got_sample), $signed(want_sample)));
        end
        if (got_last !== want_last) begin
            report($sformatf("last got %b want %b", got_last, want_last));
        end
        checked++;
    endtask
endclass

module tb;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_cmd;
    logic [22:0] i_start_step;
    logic [22:0] i_end_step;
    logic [15:0] i_length_samples;
    logic [15:0] i_volume;
    logic        o_out_valid;
    logic        i_out_ready;
    logic signed [15:0] o_sample;
    logic        o_last;

    sample_scoreboard sb;
    bit in_idle_en;
    bit out_idle_en;
    int out_stall;
    int cycles;

    tone_sweep_envelope_synth_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_start_step     (i_start_step),
        .i_end_step       (i_end_step),
        .i_length_samples (i_length_samples),
        .i_volume         (i_volume),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_sample         (o_sample),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side with random stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_sample(o_sample, o_last);
        end
        if (out_stall > 0) begin
            out_stall   <= out_stall - 1;
            i_out_ready <= 1'b0;
        end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
            out_stall   <= $urandom_range(1, 10) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_request(logic cmd, logic [22:0] st, logic [22:0] en,
                                logic [15:0] len, logic [15:0] vol);
        if (in_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_cmd            <= cmd;
        i_start_step     <= st;
        i_end_step       <= en;
        i_length_samples <= len;
        i_volume         <= vol;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(cmd, st, en, len, vol);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_request(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(bit [15:0] attack, bit [15:0] rel);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ATTACK;
        i_cfg_wdata <= attack;
        @(posedge i_clk);
        i_cfg_index <= CFG_RELEASE;
        i_cfg_wdata <= rel;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_lengths(attack, rel);
    endtask

    task automatic directed_notes();
        // idle tick before any note
        send_request(CMD_TICK, '0, '0, '0, '0);
        // zero length leaves the block idle
        send_request(CMD_START, 23'h7FFFFF, 23'h7FFFFF, 16'd0, 16'hFFFF);
        send_ticks(1);
        // top steps and volume, short note inside the fade-in
        send_request(CMD_START, 23'h7FFFFF, 23'h7FFFFF, 16'd3, 16'hFFFF);
        send_ticks(3);
        // up sweep dropped by a down sweep
        send_request(CMD_START, 23'd0, 23'h7FFFFF, 16'd4, 16'h8000);
        send_ticks(2);
        send_request(CMD_START, 23'h7FFFFF, 23'd0, 16'hFFFF, 16'hFFFF);
        send_ticks(3);
        // single sample note, then idle
        send_request(CMD_START, 23'h400000, 23'h400000, 16'd1, 16'hFFFF);
        send_ticks(2);
        wait_drain();
        configure(16'd1, 16'd1);
        // shortest ramps
        send_request(CMD_START, 23'h100000, 23'h100000, 16'd5, 16'hFFFF);
        send_ticks(5);
    endtask

    task automatic random_notes(int count);
        int        sent;
        int        mode;
        int        ticks;
        bit [22:0] st;
        bit [22:0] en;
        bit [15:0] len;
        bit [15:0] vol;
        sent = 0;
        while (sent < count) begin
            mode = $urandom_range(0, 99);
            if (mode < 10) begin
                // lone tick or start with raw fields
                send_request($urandom_range(0, 1) ? CMD_START : CMD_TICK,
                             $urandom, $urandom, $urandom, $urandom);
                sent++;
            end else begin
                st = $urandom;
                case ($urandom_range(0, 3))
                    0: begin
                        en = st;
                    end
                    1: begin
                        en = $urandom_range(0, 1) ? 23'h7FFFFF : 23'd0;
                    end
                    default: begin
                        en = $urandom;
                    end
                endcase
                len = (mode < 85) ? $urandom_range(1, 48) : $urandom_range(49, 200);
                vol = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
                send_request(CMD_START, st, en, len, vol);
                // some notes are cut short by the next start
                if ($urandom_range(0, 7) == 0) begin
                    ticks = $urandom_range(0, len - 1);
                end else begin
                    ticks = len + $urandom_range(0, 1);
                end
                if (ticks > count - sent - 1) begin
                    ticks = count - sent - 1;
                end
                send_ticks(ticks);
                sent += 1 + ticks;
            end
        end
    endtask

    initial begin
        sb               = new();
        cycles           = 0;
        out_stall        = 0;
        in_idle_en       = 1'b1;
        out_idle_en      = 1'b1;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_ATTACK;
        i_cfg_wdata      <= '0;
        i_in_valid       <= 1'b0;
        i_cmd            <= CMD_TICK;
        i_start_step     <= '0;
        i_end_step       <= '0;
        i_length_samples <= '0;
        i_volume         <= '0;
        i_out_ready      <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_notes();

        wait_drain();
        configure(16'd0, 16'd0);
        random_notes(80);

        wait_drain();
        configure(16'hFFFF, 16'hFFFF);
        random_notes(60);

        wait_drain();
        configure(16'd3, 16'd7);
        random_notes(90);

        wait_drain();
        configure($urandom_range(1, 64), $urandom_range(1, 64));
        random_notes(90);

        wait_drain();
        configure($urandom, $urandom);
        random_notes(60);

        // no idling in the last part
        wait_drain();
        configure($urandom_range(1, 32), $urandom_range(1, 32));
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        random_notes(70);

        wait_drain();
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
